FILE: hdl/ddo_pkg.sv
// Shared constants, types and helper functions for the differential drive odometry block.
// No dependencies; every other file in hdl/ imports this package.
package ddo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int COUNT_WIDTH  = 32;

    localparam int STEP_W  = $clog2(CORDIC_STEPS);
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int XY_W    = 32;
    localparam int ANG_W   = 27;
    localparam int RED_W   = 42;
    localparam int RED_TOP = 13;
    localparam int RED_K_W = $clog2(RED_TOP + 1);
    localparam int DIST_W  = 24;
    localparam int TRK_W   = 32;
    localparam int POS_W   = 32;

    localparam logic signed [ANG_W-1:0] PI_Q      = 27'sd52707179;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 27'sd26353589;
    localparam logic [RED_W-1:0]        TWO_PI_Q  = 42'd105414358;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 32'sd652032874;

    localparam logic [23:0] ATAN_Q24 [32] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2,
        24'd1,        24'd0,       24'd0,       24'd0,
        24'd0,        24'd0,       24'd0,       24'd0
    };

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_ZERO = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_LEFT_DIST   = 2'd0,
        REG_RIGHT_DIST  = 2'd1,
        REG_TRACK_RECIP = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_DIFF,
        S_MUL_T,
        S_TURN,
        S_WAIT,
        S_MUL_X,
        S_MUL_Y,
        S_ACC_Y,
        S_OUT
    } t_state;

    // Clamp a full product to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) begin
            r = v[31:0];
        end else if (v[PROD_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: hdl/differential_drive_odometry.sv
// Differential drive wheel odometry: pose tracking from two encoder counts.
// Depends on ddo_pkg, ddo_mul, ddo_cordic and ddo_wrap.
//
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_ready) carrying a command,
//   both encoder counts and a pose to load. Each request yields one result on the
//   output channel (o_out_valid / i_out_ready): the pose after that request.
//   Command 0 advances the pose from the count deltas, command 1 loads a pose
//   (heading wrapped into [-pi,pi)), command 2 zeroes the pose and latches the counts,
//   command 3 reports the pose unchanged.
//   The result of an update tick waits on the CORDIC step counter (24 steps, one per
//   cycle) running beside the delta products and the heading reduction, followed by two
//   products on the shared multiplier and the output load. A pose load waits on the
//   14-step heading reduction; commands 2 and 3 go straight to the output load. The
//   block handles one request at a time and is not ready meanwhile.
//   The result sits in an output register; a new request is taken while it waits,
//   and the next result holds back until the receiver has taken the previous one.
//   Reset (synchronous, active low) clears the pose, latched counts, the three
//   configuration registers and the output valid flag. Configuration writes are taken
//   at once and should only be issued while the block is idle.
module differential_drive_odometry (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_command,
    input  logic signed [31:0]                  i_left_count,
    input  logic signed [31:0]                  i_right_count,
    input  logic signed [31:0]                  i_new_x,
    input  logic signed [31:0]                  i_new_y,
    input  logic signed [ddo_pkg::ANG_W-1:0]    i_new_heading,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [31:0]                  o_pos_x,
    output logic signed [31:0]                  o_pos_y,
    output logic signed [ddo_pkg::ANG_W-1:0]    o_heading
);
    import ddo_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [DIST_W-1:0]              r_left_dist;
    logic [DIST_W-1:0]              r_right_dist;
    logic [TRK_W-1:0]               r_track;

    t_cmd                           r_cmd;
    logic [COUNT_WIDTH-1:0]         r_last_left;
    logic [COUNT_WIDTH-1:0]         r_last_right;
    logic signed [COUNT_WIDTH-1:0]  r_delta_l;
    logic signed [COUNT_WIDTH-1:0]  r_delta_r;
    logic signed [31:0]             r_dl;
    logic signed [31:0]             r_dr;
    logic signed [31:0]             r_travel;
    logic signed [POS_W-1:0]        r_x;
    logic signed [POS_W-1:0]        r_y;
    logic signed [ANG_W-1:0]        r_heading;

    logic                           r_out_valid;
    logic signed [POS_W-1:0]        r_out_x;
    logic signed [POS_W-1:0]        r_out_y;
    logic signed [ANG_W-1:0]        r_out_heading;

    logic                           in_acc;
    logic                           out_free;
    t_cmd                           in_cmd;
    logic [COUNT_WIDTH-1:0]         cur_left;
    logic [COUNT_WIDTH-1:0]         cur_right;

    logic signed [MUL_W-1:0]        mul_a;
    logic signed [MUL_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]       mul_prod;
    logic signed [31:0]             prod_sat;

    logic signed [32:0]             diff_wide;
    logic signed [31:0]             diff_sat;
    logic signed [32:0]             sum_wide;

    logic                           rot_start;
    logic                           rot_busy;
    logic                           wrap_start;
    logic                           wrap_busy;
    logic signed [XY_W-1:0]         cos_v;
    logic signed [XY_W-1:0]         sin_v;
    logic signed [RED_W-1:0]        wrap_in;
    logic signed [ANG_W-1:0]        wrap_heading;
    logic signed [POS_W-1:0]        pos_step;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_cmd     = t_cmd'(i_command);
    assign cur_left   = i_left_count[COUNT_WIDTH-1:0];
    assign cur_right  = i_right_count[COUNT_WIDTH-1:0];

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_angle (r_heading),
        .o_busy  (rot_busy),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    ddo_wrap u_wrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (wrap_start),
        .i_value   (wrap_in),
        .o_busy    (wrap_busy),
        .o_heading (wrap_heading)
    );

    assign prod_sat  = sat32(mul_prod);
    assign diff_wide = 33'(r_dr) - 33'(r_dl);
    assign diff_sat  = (diff_wide[32] != diff_wide[31])
                     ? (diff_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                     : diff_wide[31:0];
    assign sum_wide  = 33'(r_dl) + 33'(r_dr);
    assign pos_step  = POS_W'(mul_prod >>> 38);

    // Rotation starts on the old heading as soon as an update tick is taken
    assign rot_start  = in_acc && (in_cmd == CMD_TICK);
    assign wrap_start = (in_acc && (in_cmd == CMD_LOAD)) || (r_state == S_TURN);

    always_comb begin
        if (r_state == S_TURN) begin
            wrap_in = RED_W'(r_heading) + RED_W'(signed'(mul_prod[64:24])) + RED_W'(PI_Q);
        end else begin
            wrap_in = RED_W'(i_new_heading) + RED_W'(PI_Q);
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL_L: begin
                mul_a = MUL_W'(r_delta_l);
                mul_b = MUL_W'(r_left_dist);
            end
            S_MUL_R: begin
                mul_a = MUL_W'(r_delta_r);
                mul_b = MUL_W'(r_right_dist);
            end
            S_MUL_T: begin
                mul_a = MUL_W'(diff_sat);
                mul_b = MUL_W'(r_track);
            end
            S_MUL_X: begin
                mul_a = MUL_W'(r_travel);
                mul_b = MUL_W'(cos_v);
            end
            S_MUL_Y: begin
                mul_a = MUL_W'(r_travel);
                mul_b = MUL_W'(sin_v);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        CMD_TICK: n_state = S_MUL_L;
                        CMD_LOAD: n_state = S_WAIT;
                        CMD_ZERO: n_state = S_OUT;
                        CMD_NONE: n_state = S_OUT;
                    endcase
                end
            end
            S_MUL_L: n_state = S_MUL_R;
            S_MUL_R: n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL_T;
            S_MUL_T: n_state = S_TURN;
            S_TURN:  n_state = S_WAIT;
            S_WAIT: begin
                if (!rot_busy && !wrap_busy) begin
                    n_state = (r_cmd == CMD_TICK) ? S_MUL_X : S_OUT;
                end
            end
            S_MUL_X: n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_ACC_Y;
            S_ACC_Y: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dist  <= '0;
            r_right_dist <= '0;
            r_track      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LEFT_DIST:   r_left_dist  <= i_cfg_data[DIST_W-1:0];
                REG_RIGHT_DIST:  r_right_dist <= i_cfg_data[DIST_W-1:0];
                REG_TRACK_RECIP: r_track      <= i_cfg_data[TRK_W-1:0];
                REG_UNUSED:      ;
            endcase
        end
    end

    // Pose and latched counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CMD_NONE;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_heading    <= '0;
        end else begin
            if (in_acc) begin
                r_cmd <= in_cmd;
                unique case (in_cmd)
                    CMD_TICK: begin
                        r_last_left  <= cur_left;
                        r_last_right <= cur_right;
                    end
                    CMD_LOAD: begin
                        r_x <= i_new_x;
                        r_y <= i_new_y;
                    end
                    CMD_ZERO: begin
                        r_last_left  <= cur_left;
                        r_last_right <= cur_right;
                        r_x          <= '0;
                        r_y          <= '0;
                        r_heading    <= '0;
                    end
                    CMD_NONE: ;
                endcase
            end
            if ((r_state == S_WAIT) && !rot_busy && !wrap_busy) begin
                r_heading <= wrap_heading;
            end
            if (r_state == S_MUL_Y) begin
                r_x <= r_x + pos_step;
            end
            if (r_state == S_ACC_Y) begin
                r_y <= r_y + pos_step;
            end
        end
    end

    // Working values of the update tick
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_delta_l <= signed'(cur_left - r_last_left);
            r_delta_r <= signed'(cur_right - r_last_right);
        end
        if (r_state == S_MUL_R) begin
            r_dl <= prod_sat;
        end
        if (r_state == S_DIFF) begin
            r_dr <= prod_sat;
        end
        if (r_state == S_MUL_T) begin
            r_travel <= sum_wide[32:1];
        end
    end

    // Output register: hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_x       <= r_x;
            r_out_y       <= r_y;
            r_out_heading <= r_heading;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_heading   = r_out_heading;

endmodule

FILE: hdl/ddo_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ddo_pkg for operand and product widths.
module ddo_mul (
    input  logic                                i_clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]    i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]    i_b,
    output logic signed [ddo_pkg::PROD_W-1:0]   o_prod
);
    import ddo_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/ddo_cordic.sv
// Iterative rotation-mode CORDIC: cos and sin of a heading in [-pi,pi), one step per cycle.
// Depends on ddo_pkg for the arctangent table, gain and widths.
module ddo_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ddo_pkg::ANG_W-1:0]   i_angle,
    output logic                               o_busy,
    output logic signed [ddo_pkg::XY_W-1:0]    o_cos,
    output logic signed [ddo_pkg::XY_W-1:0]    o_sin
);
    import ddo_pkg::*;

    logic                     r_busy;
    logic [STEP_W-1:0]        r_cnt;
    logic signed [XY_W-1:0]   r_x;
    logic signed [XY_W-1:0]   r_y;
    logic signed [ANG_W-1:0]  r_z;
    logic                     r_neg;

    logic signed [ANG_W:0]    fold_wide;
    logic signed [ANG_W-1:0]  fold_angle;
    logic                     fold_neg;
    logic signed [XY_W-1:0]   x_sh;
    logic signed [XY_W-1:0]   y_sh;
    logic signed [ANG_W-1:0]  atan_step;

    // Fold headings beyond a quarter turn back by pi and negate the result
    always_comb begin
        fold_wide = (ANG_W+1)'(i_angle);
        fold_neg  = 1'b0;
        if (i_angle > HALF_PI_Q) begin
            fold_wide = (ANG_W+1)'(i_angle) - (ANG_W+1)'(PI_Q);
            fold_neg  = 1'b1;
        end else if (i_angle < -HALF_PI_Q) begin
            fold_wide = (ANG_W+1)'(i_angle) + (ANG_W+1)'(PI_Q);
            fold_neg  = 1'b1;
        end
        fold_angle = fold_wide[ANG_W-1:0];
    end

    assign x_sh      = r_x >>> r_cnt;
    assign y_sh      = r_y >>> r_cnt;
    assign atan_step = signed'(ANG_W'(ATAN_Q24[5'(r_cnt)]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= fold_angle;
            r_neg <= fold_neg;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_step;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_step;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

FILE: hdl/ddo_wrap.sv
// Iterative reduction of a wide heading sum into [-pi,pi), one shifted subtract per cycle.
// Depends on ddo_pkg for the reduction width and the pi constants.
module ddo_wrap (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ddo_pkg::RED_W-1:0]   i_value,
    output logic                               o_busy,
    output logic signed [ddo_pkg::ANG_W-1:0]   o_heading
);
    import ddo_pkg::*;

    logic                 r_busy;
    logic [RED_K_W-1:0]   r_k;
    logic [RED_W-1:0]     r_v;

    logic [RED_W-1:0]     step_mod;
    logic [RED_W-1:0]     centred;

    assign step_mod = TWO_PI_Q << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= RED_K_W'(RED_TOP);
        end else if (r_busy) begin
            if (r_k == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k - 1'b1;
            end
        end
    end

    // The incoming value already carries the +pi offset; lift negatives by a large multiple
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_value[RED_W-1]) begin
                r_v <= RED_W'(i_value) + (TWO_PI_Q << RED_TOP);
            end else begin
                r_v <= RED_W'(i_value);
            end
        end else if (r_busy) begin
            if (r_v >= step_mod) begin
                r_v <= r_v - step_mod;
            end
        end
    end

    assign centred   = r_v - RED_W'(PI_Q);
    assign o_busy    = r_busy;
    assign o_heading = signed'(centred[ANG_W-1:0]);

endmodule

FILE: tb/tb_differential_drive_odometry.sv
// Self-checking testbench for the differential drive odometry block.
// Depends on ddo_pkg and the block itself; a scoreboard class predicts every pose.
module tb_differential_drive_odometry;
    import ddo_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    localparam int Q24_PI      = 52707179;
    localparam int Q24_TWO_PI  = 105414358;
    localparam int Q24_HALF_PI = 26353589;
    localparam int Q30_GAIN    = 652032874;
    localparam longint COUNT_MASK = (longint'(1) << COUNT_WIDTH) - 1;

    localparam int ARC_TAN [32] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic signed [31:0]      x;
        logic signed [31:0]      y;
        logic signed [ANG_W-1:0] h;
    } t_pose;

    class odometry_scoreboard;
        logic [23:0]             left_dist;
        logic [23:0]             right_dist;
        logic [31:0]             track_recip;
        logic [31:0]             left_latch;
        logic [31:0]             right_latch;
        logic [31:0]             x_pos;
        logic [31:0]             y_pos;
        logic signed [ANG_W-1:0] head;
        t_pose                   poses_due [$];
        int                      errors;
        int                      checked;

        function new();
            left_dist   = '0;
            right_dist  = '0;
            track_recip = '0;
            left_latch  = '0;
            right_latch = '0;
            x_pos       = '0;
            y_pos       = '0;
            head        = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_LEFT_DIST:   left_dist = value[23:0];
                REG_RIGHT_DIST:  right_dist = value[23:0];
                REG_TRACK_RECIP: track_recip = value;
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Wrapping count difference, read as signed at the counter width
        function longint wheel_delta(logic [31:0] cur, logic [31:0] last);
            longint d;
            d = (longint'(cur) - longint'(last)) & COUNT_MASK;
            if (d[COUNT_WIDTH-1]) d = d - (longint'(1) << COUNT_WIDTH);
            return d;
        endfunction

        function logic signed [ANG_W-1:0] wrap_angle(longint v);
            longint r;
            r = (v + Q24_PI) % Q24_TWO_PI;
            if (r < 0) r = r + Q24_TWO_PI;
            r = r - Q24_PI;
            return r[ANG_W-1:0];
        endfunction

        // Rotation-mode CORDIC; fold headings beyond a quarter turn and negate
        function void cos_sin(logic signed [ANG_W-1:0] h, output longint c, output longint s);
            longint a, x, y, z, xs, ys;
            bit     flip;
            a = h;
            flip = 0;
            x = Q30_GAIN;
            y = 0;
            if (a > Q24_HALF_PI) begin
                a = a - Q24_PI;
                flip = 1;
            end else if (a < -Q24_HALF_PI) begin
                a = a + Q24_PI;
                flip = 1;
            end
            z = a;
            for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARC_TAN[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARC_TAN[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_request(logic [1:0] cmd, logic [31:0] lc, logic [31:0] rc,
                                   logic [31:0] nx, logic [31:0] ny, logic [31:0] nh32);
            longint                  cl, cr, dl, dr, travel, diff, turn, c, s, step;
            logic signed [ANG_W-1:0] nh;
            t_pose                   p;
            cl = longint'(lc) & COUNT_MASK;
            cr = longint'(rc) & COUNT_MASK;
            nh = nh32[ANG_W-1:0];
            case (cmd)
                CMD_TICK: begin
                    dl = clamp32(wheel_delta(cl[31:0], left_latch) * longint'(left_dist));
                    dr = clamp32(wheel_delta(cr[31:0], right_latch) * longint'(right_dist));
                    travel = (dl + dr) >>> 1;
                    diff = clamp32(dr - dl);
                    turn = (diff * longint'(track_recip)) >>> 24;
                    left_latch = cl[31:0];
                    right_latch = cr[31:0];
                    // Step along the old heading, then turn
                    cos_sin(head, c, s);
                    step = (travel * c) >>> 38;
                    x_pos = x_pos + step[31:0];
                    step = (travel * s) >>> 38;
                    y_pos = y_pos + step[31:0];
                    head = wrap_angle(longint'(head) + turn);
                end
                CMD_LOAD: begin
                    x_pos = nx;
                    y_pos = ny;
                    head = wrap_angle(longint'(nh));
                end
                CMD_ZERO: begin
                    x_pos = '0;
                    y_pos = '0;
                    head = '0;
                    left_latch = cl[31:0];
                    right_latch = cr[31:0];
                end
                default: ;
            endcase
            p.x = x_pos;
            p.y = y_pos;
            p.h = head;
            poses_due.push_back(p);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 60)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        endfunction

        function void check_pose(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [ANG_W-1:0] h);
            t_pose want;
            if (poses_due.size() == 0) begin
                flag("unrequested result x", 32'd0, x);
                return;
            end
            want = poses_due.pop_front();
            checked++;
            if (x !== want.x) flag("pos_x", want.x, x);
            if (y !== want.y) flag("pos_y", want.y, y);
            if (h !== want.h)
                flag("heading", {{(32-ANG_W){1'b0}}, want.h}, {{(32-ANG_W){1'b0}}, h});
        endfunction

        function int pending();
            return poses_due.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_index = '0;
    logic [31:0]             cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              command = '0;
    logic signed [31:0]      left_count = '0;
    logic signed [31:0]      right_count = '0;
    logic signed [31:0]      new_x = '0;
    logic signed [31:0]      new_y = '0;
    logic signed [ANG_W-1:0] new_heading = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [31:0]      pos_x;
    logic signed [31:0]      pos_y;
    logic signed [ANG_W-1:0] heading;

    odometry_scoreboard sb = new();
    bit          send_calm = 1'b0;
    int          sent = 0;
    int          settings_written = 0;
    logic [31:0] cur_left = '0;
    logic [31:0] cur_right = '0;

    differential_drive_odometry i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (command),
        .i_left_count  (left_count),
        .i_right_count (right_count),
        .i_new_x       (new_x),
        .i_new_y       (new_y),
        .i_new_heading (new_heading),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y),
        .o_heading     (heading)
    );

    always #5 clk = ~clk;

    task automatic write_settings(logic [31:0] l, logic [31:0] r, logic [31:0] t);
        cfg_we <= 1'b1;
        cfg_index <= REG_LEFT_DIST;
        cfg_data <= {8'd0, l[23:0]};
        @(posedge clk);
        cfg_index <= REG_RIGHT_DIST;
        cfg_data <= {8'd0, r[23:0]};
        @(posedge clk);
        cfg_index <= REG_TRACK_RECIP;
        cfg_data <= t;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(REG_LEFT_DIST, l);
        sb.set_reg(REG_RIGHT_DIST, r);
        sb.set_reg(REG_TRACK_RECIP, t);
        settings_written++;
    endtask

    // Hold valid across back-to-back requests; drop it only for a real gap
    task automatic send_request(logic [1:0] cmd, logic [31:0] lc, logic [31:0] rc,
                                logic [31:0] nx, logic [31:0] ny, logic [31:0] nh);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        left_count <= lc;
        right_count <= rc;
        new_x <= nx;
        new_y <= ny;
        new_heading <= nh[ANG_W-1:0];
        do @(posedge clk); while (!in_ready);
        sb.note_request(cmd, lc, rc, nx, ny, nh);
        sent++;
        if (sent % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic end_phase();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Mostly realistic wheel motion, some long jumps, a little noise
    function automatic logic [31:0] next_count(logic [31:0] c);
        int q, step;
        q = $urandom_range(0, 9);
        if (q < 7) return c + $urandom_range(0, 4000) - 32'd2000;
        if (q < 9) begin
            step = $urandom;
            step = step >>> $urandom_range(4, 20);
            return c + step;
        end
        return $urandom;
    endfunction

    task automatic random_request();
        int p, hv;
        p = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) hv = $urandom;
        else hv = int'($urandom_range(0, Q24_TWO_PI - 1)) - Q24_PI;
        if (p < 70) begin
            cur_left = next_count(cur_left);
            cur_right = next_count(cur_right);
            send_request(CMD_TICK, cur_left, cur_right, $urandom, $urandom, hv);
        end else if (p < 85) begin
            send_request(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, hv);
        end else if (p < 95) begin
            if ($urandom_range(0, 1) == 1) begin
                cur_left = $urandom;
                cur_right = $urandom;
            end
            send_request(CMD_ZERO, cur_left, cur_right, $urandom, $urandom, hv);
        end else begin
            send_request(CMD_NONE, $urandom, $urandom, $urandom, $urandom, hv);
        end
    endtask

    // Result side: random stalls with calm stretches
    initial begin
        int gap, taken;
        bit take_calm;
        taken = 0;
        take_calm = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = take_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_pose(pos_x, pos_y, heading);
            taken++;
            if (taken % 40 == 0) take_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timed out with %0d results outstanding", sb.pending());
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Registers still at reset: ticks must not move the pose
        send_request(CMD_TICK, 32'd100, -32'sd100, $urandom, $urandom, $urandom);
        send_request(CMD_ZERO, 32'd0, 32'd0, $urandom, $urandom, $urandom);
        end_phase();

        write_settings(32'h010000, 32'h010000, 32'h02000000);
        send_request(CMD_TICK, 32'd1000, 32'd1000, $urandom, $urandom, $urandom);
        send_request(CMD_TICK, 32'd2000, 32'd3500, $urandom, $urandom, $urandom);
        send_request(CMD_TICK, -32'sd5000, 32'd9000, $urandom, $urandom, $urandom);
        send_request(CMD_LOAD, $urandom, $urandom, 32'h7FFFFFFF, 32'h80000000, Q24_PI - 1);
        send_request(CMD_TICK, -32'sd1000, 32'd12000, $urandom, $urandom, $urandom);
        send_request(CMD_LOAD, $urandom, $urandom, 32'h80000000, 32'h7FFFFFFF, -Q24_PI);
        send_request(CMD_TICK, 32'd3000, 32'd12000, $urandom, $urandom, $urandom);
        // Headings either side of a quarter turn exercise the fold
        send_request(CMD_LOAD, $urandom, $urandom, 32'd0, 32'd0, Q24_HALF_PI + 1);
        send_request(CMD_TICK, 32'd4000, 32'd13000, $urandom, $urandom, $urandom);
        send_request(CMD_LOAD, $urandom, $urandom, 32'd0, 32'd0, -Q24_HALF_PI - 1);
        send_request(CMD_TICK, 32'd5000, 32'd14000, $urandom, $urandom, $urandom);
        send_request(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, Q24_HALF_PI);
        send_request(CMD_TICK, 32'd6000, 32'd14000, $urandom, $urandom, $urandom);
        // Loaded headings outside the range wrap back in
        send_request(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, 32'h03FFFFFF);
        send_request(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, 32'h04000000);
        send_request(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        // Counter rollover across the signed boundary
        send_request(CMD_ZERO, 32'h7FFFFFF0, 32'h80000010, $urandom, $urandom, $urandom);
        send_request(CMD_TICK, 32'h80000010, 32'h7FFFFFF0, $urandom, $urandom, $urandom);
        end_phase();

        // Largest distances and reciprocal: scaled deltas and their difference saturate
        write_settings(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF);
        send_request(CMD_ZERO, 32'd0, 32'd0, $urandom, $urandom, $urandom);
        send_request(CMD_TICK, 32'h7FFFFFFF, 32'h80000000, $urandom, $urandom, $urandom);
        send_request(CMD_TICK, 32'hFFFFFFFE, 32'h7FFFFFFF, $urandom, $urandom, $urandom);
        send_request(CMD_TICK, 32'hFFFFFF00, 32'h7FFFFFF0, $urandom, $urandom, $urandom);
        send_request(CMD_TICK, 32'h7FFFFF00, 32'hFFFFFFF0, $urandom, $urandom, $urandom);
        end_phase();

        cur_left = 32'h7FFFFF00;
        cur_right = 32'hFFFFFFF0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_settings($urandom_range(32'h4000, 32'h40000),
                                  $urandom_range(32'h4000, 32'h40000),
                                  $urandom_range(32'h800000, 32'h8000000));
                1: write_settings($urandom, $urandom, $urandom);
                2: write_settings(32'h000000, 32'hFFFFFF, 32'h0);
                3: write_settings(32'hFFFFFF, 32'h000000, 32'hFFFFFFFF);
                default: write_settings($urandom_range(32'h100, 32'h100000),
                                        $urandom_range(32'h100, 32'h100000),
                                        $urandom);
            endcase
            repeat (190) random_request();
            end_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d requests (ticks, pose loads, zeroing, unused code) over %0d settings",
                 sent, settings_written);
        $display("Compared %0d poses, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ddo_pkg.sv
hdl/ddo_mul.sv
hdl/ddo_cordic.sv
hdl/ddo_wrap.sv
hdl/differential_drive_odometry.sv
tb/tb_differential_drive_odometry.sv
